@@ src/multi_queue_task_dispatcher_defines.svh @@
// ----------------------------------------------------------------------------
// multi_queue_task_dispatcher assertion macros
// shared assertion forms for the dispatcher checkers
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_TASK_DISPATCHER_DEFINES_SVH
`define MULTI_QUEUE_TASK_DISPATCHER_DEFINES_SVH

// same-cycle implication, held off during reset
`define MQTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MQTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mqtd_pkg.sv @@
// ----------------------------------------------------------------------------
// mqtd_pkg
// types, codes and helpers shared by the task dispatcher modules
// ----------------------------------------------------------------------------
package mqtd_pkg;

  localparam int TASK_W = 32;
  localparam int ACT_W  = 6;
  localparam int CFG_W  = 16;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_BAL = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  localparam logic [1:0] POL_RR    = 2'd0;
  localparam logic [1:0] POL_RAND  = 2'd1;
  localparam logic [1:0] POL_LEAST = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_BAL,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_PICK,
    S_MOD,
    S_ENQ,
    S_DEQ_OUT
  } mqtd_state_e;

  typedef struct packed {
    op_e               op;
    logic [TASK_W-1:0] task_id;
    logic [2:0]        worker;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              done;
    logic [1:0]        status;
    logic [2:0]        chosen;
    logic [TASK_W-1:0] task_out;
    logic              task_valid;
  } result_t;

  // galois step, a zero value is treated as one
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = (v == 16'd0) ? 16'd1 : v;
    return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
  endfunction

endpackage

@@ src/multi_queue_task_dispatcher.sv @@
// ----------------------------------------------------------------------------
// multi_queue_task_dispatcher
// per-worker task queues with round robin, random or least loaded placement
//
//   channel   signals                                    direction
//   command   start_i busy_o action_i task_id_i worker_i  in
//   result    done_o status_o chosen_worker_o task_out_o  out
//             task_valid_o
//   config    cfg_we_i cfg_idx_i cfg_data_i               in
//
// a successful dequeue reads the head entry and returns it from S_DEQ_OUT; a failed
// dequeue or a rebalance request is answered straight from S_IDLE
// an enqueue picks its worker with a 16-step remainder unit under round robin or
// random, by a scan of occupancies under least loaded (one occupancy per cycle)
// a pending rebalance first moves tasks from fullest to emptiest queue in the next enqueue
// a two-entry command queue sits in front; busy_o is high while it is full
// results are shown for one cycle on done_o; reset clears all queues
// ----------------------------------------------------------------------------
module multi_queue_task_dispatcher import mqtd_pkg::*; #(
  parameter int NUM_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        action_i,
  input  logic [TASK_W-1:0] task_id_i,
  input  logic [2:0]        worker_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [2:0]        chosen_worker_o,
  output logic [TASK_W-1:0] task_out_o,
  output logic              task_valid_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  cfg_wr_t cfg;
  result_t res;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};

  mqtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_i),
    .task_id_i   (task_id_i),
    .worker_i    (worker_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mqtd_back #(
    .NUM_WORKERS (NUM_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .result_o    (res)
  );

  assign done_o          = res.done;
  assign status_o        = res.status;
  assign chosen_worker_o = res.chosen;
  assign task_out_o      = res.task_out;
  assign task_valid_o    = res.task_valid;

endmodule

@@ src/mqtd_front.sv @@
// ----------------------------------------------------------------------------
// mqtd_front
// accepts commands, decodes the action and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module mqtd_front import mqtd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        action_i,
  input  logic [TASK_W-1:0] task_id_i,
  input  logic [2:0]        worker_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  op_e        op;

  always_comb begin
    unique case (action_i)
      ACT_ENQ: op = OP_ENQ;
      ACT_DEQ: op = OP_DEQ;
      ACT_BAL: op = OP_BAL;
      default: op = OP_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = ent_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= '{op: op, task_id: task_id_i, worker: worker_i};
    end
  end

endmodule

@@ src/mqtd_back.sv @@
// ----------------------------------------------------------------------------
// mqtd_back
// executes queued commands on the per-worker ring queues
// ----------------------------------------------------------------------------
module mqtd_back import mqtd_pkg::*; #(
  parameter int NUM_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output result_t result_o
);

  localparam int WIDX      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int OW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_WORKERS * QUEUE_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  mqtd_state_e state_q, state_d;

  logic [PW-1:0] head_q [NUM_WORKERS];
  logic [PW-1:0] head_d [NUM_WORKERS];
  logic [PW-1:0] tail_q [NUM_WORKERS];
  logic [PW-1:0] tail_d [NUM_WORKERS];
  logic [OW-1:0] occ_q  [NUM_WORKERS];
  logic [OW-1:0] occ_d  [NUM_WORKERS];

  logic [1:0]      policy_q;
  logic [3:0]      active_q;
  logic [15:0]     lfsr_q, lfsr_d;
  logic            pending_q, pending_d;
  logic [WIDX-1:0] next_turn_q, next_turn_d;
  cmd_t            cmd_q, cmd_d;
  logic            bal_mode_q, bal_mode_d;
  logic [WIDX-1:0] scan_q, scan_d;
  logic [WIDX-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [OW-1:0]   lo_occ_q, lo_occ_d, hi_occ_q, hi_occ_d;
  logic [OW-1:0]   mv_q, mv_d;
  logic [WIDX-1:0] chosen_q, chosen_d;
  logic [15:0]     div_q, div_d;
  logic [5:0]      rem_q, rem_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            is_rr_q, is_rr_d;
  result_t         res_q, res_d;

  logic [TASK_W-1:0] mem [MEM_DEPTH];
  logic [TASK_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [TASK_W-1:0] mem_wdata;

  logic [ACT_W-1:0] act_n;
  logic [WIDX-1:0]  sel_w;
  logic [OW-1:0]    sel_occ;
  logic [PW-1:0]    sel_head, sel_tail, ptr;
  logic [OW-1:0]    moves;
  logic [6:0]       sh;
  logic [15:0]      lv;

  function automatic logic [AW-1:0] qaddr(input logic [WIDX-1:0] w,
                                          input logic [PW-1:0] p);
    return AW'(int'(w) * QUEUE_DEPTH + int'(p));
  endfunction

  function automatic logic [PW-1:0] pnext(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] pprev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
  endfunction

  // active worker count, zero reads as one and large values saturate
  always_comb begin
    if (active_q == 4'd0) begin
      act_n = ACT_W'(1);
    end else if (int'(active_q) > NUM_WORKERS) begin
      act_n = ACT_W'(NUM_WORKERS);
    end else begin
      act_n = ACT_W'(active_q);
    end
  end

  // one worker slot is looked at per cycle
  always_comb begin
    unique case (state_q)
      S_IDLE:  sel_w = WIDX'(cmd_i.worker);
      S_SCAN:  sel_w = scan_q;
      S_MV_RD: sel_w = hi_q;
      S_MV_WR: sel_w = lo_q;
      default: sel_w = chosen_q;
    endcase
  end

  assign sel_occ  = occ_q[sel_w];
  assign sel_head = head_q[sel_w];
  assign sel_tail = tail_q[sel_w];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    lfsr_d      = lfsr_q;
    pending_d   = pending_q;
    next_turn_d = next_turn_q;
    cmd_d       = cmd_q;
    bal_mode_d  = bal_mode_q;
    scan_d      = scan_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lo_occ_d    = lo_occ_q;
    hi_occ_d    = hi_occ_q;
    mv_d        = mv_q;
    chosen_d    = chosen_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    is_rr_d     = is_rr_q;
    res_d       = '0;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;
    ptr         = '0;
    moves       = '0;
    sh          = '0;
    lv          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.op)
            OP_ENQ: begin
              if (pending_q) begin
                scan_d     = '0;
                bal_mode_d = 1'b1;
                state_d    = S_SCAN;
              end else begin
                state_d = S_PICK;
              end
            end
            OP_DEQ: begin
              if ({3'b000, cmd_i.worker} >= act_n) begin
                res_d.done   = 1'b1;
                res_d.status = ST_INACTIVE;
                res_d.chosen = cmd_i.worker;
              end else if (sel_occ == '0) begin
                res_d.done   = 1'b1;
                res_d.status = ST_EMPTY;
                res_d.chosen = cmd_i.worker;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = qaddr(sel_w, sel_head);
                head_d[sel_w] = pnext(sel_head);
                occ_d[sel_w]  = sel_occ - OW'(1);
                state_d       = S_DEQ_OUT;
              end
            end
            OP_BAL: begin
              pending_d  = 1'b1;
              res_d.done = 1'b1;
            end
            default: begin
              res_d.done = 1'b1;
            end
          endcase
        end
      end

      // min and max search, lowest index wins ties
      S_SCAN: begin
        if (scan_q == '0 || sel_occ < lo_occ_q) begin
          lo_d     = scan_q;
          lo_occ_d = sel_occ;
        end
        if (scan_q == '0 || sel_occ > hi_occ_q) begin
          hi_d     = scan_q;
          hi_occ_d = sel_occ;
        end
        if (ACT_W'(scan_q) == act_n - ACT_W'(1)) begin
          if (bal_mode_q) begin
            moves = (hi_occ_d - lo_occ_d) >> 1;
            if (moves != '0) begin
              mv_d    = moves;
              state_d = S_MV_RD;
            end else begin
              pending_d = 1'b0;
              state_d   = S_PICK;
            end
          end else begin
            chosen_d = lo_d;
            state_d  = S_ENQ;
          end
        end else begin
          scan_d = scan_q + WIDX'(1);
        end
      end

      // pop from the tail of the fullest queue
      S_MV_RD: begin
        ptr          = pprev(sel_tail);
        tail_d[hi_q] = ptr;
        occ_d[hi_q]  = sel_occ - OW'(1);
        mem_re       = 1'b1;
        mem_raddr    = qaddr(hi_q, ptr);
        state_d      = S_MV_WR;
      end

      // push onto the tail of the emptiest queue
      S_MV_WR: begin
        mem_we       = 1'b1;
        mem_waddr    = qaddr(lo_q, sel_tail);
        mem_wdata    = rdata_q;
        tail_d[lo_q] = pnext(sel_tail);
        occ_d[lo_q]  = sel_occ + OW'(1);
        mv_d         = mv_q - OW'(1);
        if (mv_q == OW'(1)) begin
          pending_d = 1'b0;
          state_d   = S_PICK;
        end else begin
          state_d = S_MV_RD;
        end
      end

      S_PICK: begin
        rem_d = '0;
        cnt_d = '0;
        unique case (policy_q)
          POL_LEAST: begin
            scan_d     = '0;
            bal_mode_d = 1'b0;
            state_d    = S_SCAN;
          end
          POL_RAND: begin
            lv      = lfsr_next(lfsr_q);
            lfsr_d  = lv;
            div_d   = lv;
            is_rr_d = 1'b0;
            state_d = S_MOD;
          end
          default: begin
            div_d   = 16'(next_turn_q);
            is_rr_d = 1'b1;
            state_d = S_MOD;
          end
        endcase
      end

      // restoring remainder, one dividend bit per cycle
      S_MOD: begin
        sh = {rem_q, div_q[15]};
        if (sh >= {1'b0, act_n}) begin
          sh = sh - {1'b0, act_n};
        end
        rem_d = sh[5:0];
        div_d = div_q << 1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          chosen_d = WIDX'(sh[5:0]);
          if (is_rr_q) begin
            if (7'(sh[5:0]) + 7'd1 >= {1'b0, act_n}) begin
              next_turn_d = '0;
            end else begin
              next_turn_d = WIDX'(sh[5:0] + 6'd1);
            end
          end
          state_d = S_ENQ;
        end
      end

      S_ENQ: begin
        res_d.done   = 1'b1;
        res_d.chosen = 3'(chosen_q);
        if (sel_occ == OW'(QUEUE_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = qaddr(chosen_q, sel_tail);
          mem_wdata        = cmd_q.task_id;
          tail_d[chosen_q] = pnext(sel_tail);
          occ_d[chosen_q]  = sel_occ + OW'(1);
        end
        state_d = S_IDLE;
      end

      S_DEQ_OUT: begin
        res_d.done       = 1'b1;
        res_d.status     = ST_OK;
        res_d.chosen     = cmd_q.worker;
        res_d.task_out   = rdata_q;
        res_d.task_valid = 1'b1;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a seed write reloads the generator
    if (cfg_i.we && cfg_i.idx == CFG_SEED) begin
      lfsr_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POL_RR;
      active_q    <= 4'd8;
      lfsr_q      <= 16'd1;
      pending_q   <= 1'b0;
      next_turn_q <= '0;
      res_q       <= '0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      pending_q   <= pending_d;
      next_turn_q <= next_turn_d;
      res_q       <= res_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      if (cfg_i.we && cfg_i.idx == CFG_POLICY) begin
        policy_q <= cfg_i.data[1:0];
      end
      if (cfg_i.we && cfg_i.idx == CFG_ACTIVE) begin
        active_q <= cfg_i.data[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    bal_mode_q <= bal_mode_d;
    scan_q     <= scan_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    lo_occ_q   <= lo_occ_d;
    hi_occ_q   <= hi_occ_d;
    mv_q       <= mv_d;
    chosen_q   <= chosen_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    is_rr_q    <= is_rr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign result_o = res_q;

endmodule

@@ src/mqtd_checker.sv @@
// ----------------------------------------------------------------------------
// mqtd_checker
// port-level checks on the dispatcher result and command channels
// ----------------------------------------------------------------------------
`include "multi_queue_task_dispatcher_defines.svh"

module mqtd_checker import mqtd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [31:0] task_out_o,
  input logic        task_valid_o
);

  // a delivered task always carries ok status
  `MQTD_ASSERT_NOW(a_valid_ok, done_o && task_valid_o, status_o == ST_OK, "task without ok status")

  // no task means a zero task field
  `MQTD_ASSERT_NOW(a_zero_out, done_o && !task_valid_o, task_out_o == 32'd0, "stray task data")

  // task_valid only travels with a strobe
  `MQTD_ASSERT_NOW(a_valid_strobe, task_valid_o, done_o, "task_valid without done")

  // the queue only fills through accepted commands
  `MQTD_ASSERT_NEXT(a_busy_cause, !busy_o && !(start_i && !busy_o), !busy_o, "busy without transaction")

endmodule

bind multi_queue_task_dispatcher mqtd_checker u_mqtd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .status_o     (status_o),
  .task_out_o   (task_out_o),
  .task_valid_o (task_valid_o)
);
